FILE: rtl/dtpc_pkg.sv
// Shared types and constants for the depth to point cloud block.
`timescale 1ns / 1ps
package dtpc_pkg;

    localparam int CfgIdxBits = 8;

    localparam logic [CfgIdxBits-1:0] REG_FRAME_SIZE      = 8'd0;
    localparam logic [CfgIdxBits-1:0] REG_INVERSE_FOCAL   = 8'd1;
    localparam logic [CfgIdxBits-1:0] REG_PRINCIPAL_POINT = 8'd2;
    localparam logic [CfgIdxBits-1:0] REG_DEPTH_MODE      = 8'd3;
    localparam logic [CfgIdxBits-1:0] REG_ROTATION_ROW0   = 8'd4;
    localparam logic [CfgIdxBits-1:0] REG_ROTATION_ROW1   = 8'd5;
    localparam logic [CfgIdxBits-1:0] REG_ROTATION_ROW2   = 8'd6;
    localparam logic [CfgIdxBits-1:0] REG_TRANSLATION     = 8'd7;

    localparam logic [4:0] STEP_X_MUL    = 5'd0;
    localparam logic [4:0] STEP_X_LO     = 5'd1;
    localparam logic [4:0] STEP_X_HI     = 5'd2;
    localparam logic [4:0] STEP_Y_MUL    = 5'd3;
    localparam logic [4:0] STEP_Y_LO     = 5'd4;
    localparam logic [4:0] STEP_Y_HI     = 5'd5;
    localparam logic [4:0] STEP_CAM_DONE = 5'd6;
    localparam logic [4:0] STEP_R00      = 5'd7;
    localparam logic [4:0] STEP_R01      = 5'd8;
    localparam logic [4:0] STEP_R02      = 5'd9;
    localparam logic [4:0] STEP_R10      = 5'd10;
    localparam logic [4:0] STEP_R11      = 5'd11;
    localparam logic [4:0] STEP_R12      = 5'd12;
    localparam logic [4:0] STEP_R20      = 5'd13;
    localparam logic [4:0] STEP_R21      = 5'd14;
    localparam logic [4:0] STEP_R22      = 5'd15;
    localparam logic [4:0] STEP_POSE_DONE = 5'd16;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CALC = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    typedef struct packed {
        logic        in_ready;
        logic        load;
        logic        run;
        logic [4:0]  step;
        logic        out_load;
    } t_cmd;

    typedef struct packed {
        logic valid;
        logic last;
        logic pose;
        logic out_free;
    } t_sts;

    typedef struct packed {
        logic [23:0] frame_size;
        logic [63:0] inverse_focal;
        logic [31:0] principal_point;
        logic [17:0] depth_mode;
        logic [47:0] rot0;
        logic [47:0] rot1;
        logic [47:0] rot2;
        logic [59:0] translation;
    } t_cfg;

endpackage

FILE: rtl/depth_to_point_cloud.sv
// Depth to point cloud top level: configuration registers and stream ports.
// An invalid pixel that ends no frame goes straight back to idle; a frame end without a point
// goes to the output state; a point is computed by one shared 33x25 multiplier stepping
// through six deprojection and, with the pose on, nine rotation products. One pixel is in
// work at a time, and the output state waits until the output register is free; a finished
// result waits in the output register while the next pixel is taken. Synchronous active-low
// reset restores the configuration defaults and clears the counters and frame state.
`timescale 1ns / 1ps
module depth_to_point_cloud
    import dtpc_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int DEPTH_BITS = 16,
    localparam int InBits = ((DEPTH_BITS + 24 + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CfgIdxBits-1:0] i_cfg_addr,
    input  logic [63:0]           i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // depth_mm, color_blue, color_green, color_red
    input  logic [InBits-1:0]     s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // point_x, point_y, point_z, out_red, out_green, out_blue
    output logic [87:0]           m_axis_tdata,
    // point_valid, frame_empty
    output logic [1:0]            m_axis_tuser,
    output logic                  m_axis_tlast
);

    t_cfg r_cfg;
    t_cmd cmd;
    t_sts sts;
    logic [19:0] px, py, pz;
    logic [7:0]  cr, cg, cb;
    logic        pv, fe, fm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_size      <= 24'd1966720;
            r_cfg.inverse_focal   <= '0;
            r_cfg.principal_point <= '0;
            r_cfg.depth_mode      <= 18'd65535;
            r_cfg.rot0            <= 48'd16384;
            r_cfg.rot1            <= 48'd1073741824;
            r_cfg.rot2            <= 48'd70368744177664;
            r_cfg.translation     <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                REG_FRAME_SIZE:      r_cfg.frame_size      <= i_cfg_data[23:0];
                REG_INVERSE_FOCAL:   r_cfg.inverse_focal   <= i_cfg_data;
                REG_PRINCIPAL_POINT: r_cfg.principal_point <= i_cfg_data[31:0];
                REG_DEPTH_MODE:      r_cfg.depth_mode      <= i_cfg_data[17:0];
                REG_ROTATION_ROW0:   r_cfg.rot0            <= i_cfg_data[47:0];
                REG_ROTATION_ROW1:   r_cfg.rot1            <= i_cfg_data[47:0];
                REG_ROTATION_ROW2:   r_cfg.rot2            <= i_cfg_data[47:0];
                REG_TRANSLATION:     r_cfg.translation     <= i_cfg_data[59:0];
                default:             r_cfg                 <= r_cfg;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    dtpc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    dtpc_dp #(
        .COORD_BITS (COORD_BITS),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg         (r_cfg),
        .i_depth       (s_axis_tdata[DEPTH_BITS-1:0]),
        .i_blue        (s_axis_tdata[DEPTH_BITS+7:DEPTH_BITS]),
        .i_green       (s_axis_tdata[DEPTH_BITS+15:DEPTH_BITS+8]),
        .i_red         (s_axis_tdata[DEPTH_BITS+23:DEPTH_BITS+16]),
        .i_out_ready   (m_axis_tready),
        .o_sts         (sts),
        .o_out_valid   (m_axis_tvalid),
        .o_x           (px),
        .o_y           (py),
        .o_z           (pz),
        .o_red         (cr),
        .o_green       (cg),
        .o_blue        (cb),
        .o_point_valid (pv),
        .o_frame_end   (fe),
        .o_frame_empty (fm)
    );

    assign s_axis_tready = cmd.in_ready;
    assign m_axis_tdata  = {4'b0, cb, cg, cr, pz, py, px};
    assign m_axis_tuser  = {fm, pv};
    assign m_axis_tlast  = fe;

endmodule

FILE: rtl/dtpc_ctrl.sv
// Sequencer that steps the datapath through one pixel request.
`timescale 1ns / 1ps
module dtpc_ctrl
    import dtpc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state     r_state, n_state;
    logic [4:0] r_step, n_step;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CALC;
                    n_step     = STEP_X_MUL;
                end
            end
            S_CALC: begin
                if (r_step == STEP_X_MUL && !i_sts.valid) begin
                    n_state = i_sts.last ? S_OUT : S_IDLE;
                end else begin
                    o_cmd.run  = 1'b1;
                    o_cmd.step = r_step;
                    if ((r_step == STEP_CAM_DONE && !i_sts.pose) ||
                        r_step == STEP_POSE_DONE) begin
                        n_state = S_OUT;
                    end else begin
                        n_step = r_step + 5'd1;
                    end
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

FILE: rtl/dtpc_dp.sv
// Datapath: pixel counters, shared multiplier, deprojection, pose and output register.
`timescale 1ns / 1ps
module dtpc_dp
    import dtpc_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int DEPTH_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  t_cfg                  i_cfg,
    input  logic [DEPTH_BITS-1:0] i_depth,
    input  logic [7:0]            i_blue,
    input  logic [7:0]            i_green,
    input  logic [7:0]            i_red,
    input  logic                  i_out_ready,
    output t_sts                  o_sts,
    output logic                  o_out_valid,
    output logic [19:0]           o_x,
    output logic [19:0]           o_y,
    output logic [19:0]           o_z,
    output logic [7:0]            o_red,
    output logic [7:0]            o_green,
    output logic [7:0]            o_blue,
    output logic                  o_point_valid,
    output logic                  o_frame_end,
    output logic                  o_frame_empty
);

    function automatic logic signed [19:0] sat_mag(input logic [45:0] q, input logic neg);
        logic signed [19:0] r;
        if (neg) begin
            r = (q >= 46'd524288) ? -20'sd524288 : 20'(-$signed({1'b0, q}));
        end else begin
            r = (q >= 46'd524287) ? 20'sd524287 : 20'(q);
        end
        return r;
    endfunction

    function automatic logic signed [19:0] deproj(input logic [45:0] phi,
                                                 input logic [55:0] plo,
                                                 input logic        neg);
        logic [46:0] s;
        logic [45:0] q;
        s = {1'b0, phi} + 47'(({1'b0, plo} + 57'h8_0000_0000) >> 32);
        q = 46'(s >> 4);
        return sat_mag(q, neg);
    endfunction

    function automatic logic signed [19:0] rot_out(input logic signed [37:0] s,
                                                  input logic signed [19:0] t);
        logic        neg;
        logic [37:0] mag;
        logic [23:0] q;
        logic signed [26:0] v;
        neg = s[37];
        mag = neg ? 38'(-s) : 38'(s);
        q   = 24'((mag + 38'd8192) >> 14);
        v   = (neg ? -$signed({3'b0, q}) : $signed({3'b0, q})) + 27'(t);
        if (v > 27'sd524287) begin
            return 20'sd524287;
        end else if (v < -27'sd524288) begin
            return -20'sd524288;
        end
        return 20'(v);
    endfunction

    logic [COORD_BITS-1:0] r_col, r_row;
    logic                  r_any;
    logic [DEPTH_BITS-1:0] r_d;
    logic [7:0]            r_cr, r_cg, r_cb;
    logic                  r_valid, r_last, r_empty;
    logic [20:0]           r_magx, r_magy;
    logic                  r_negx, r_negy;
    logic signed [57:0]    r_prod;
    logic [20:0]           r_mhi;
    logic [55:0]           r_plo;
    logic signed [19:0]    r_cx, r_cy, r_cz, r_rx, r_ry, r_rz;
    logic signed [37:0]    r_acc;
    logic                  r_ovalid;

    logic [15:0]           wm1, hm1;
    logic [COORD_BITS-1:0] wlast, hlast;
    logic                  pix_valid, pix_last;
    logic [23:0]           d24;
    logic signed [21:0]    dx, dy;
    logic signed [32:0]    mul_a;
    logic signed [24:0]    mul_b;
    logic signed [37:0]    row_sum;
    logic                  pose_on;

    assign wm1      = {4'b0, i_cfg.frame_size[11:0]} - 16'd1;
    assign hm1      = {4'b0, i_cfg.frame_size[23:12]} - 16'd1;
    assign wlast    = wm1[COORD_BITS-1:0];
    assign hlast    = hm1[COORD_BITS-1:0];
    assign d24      = 24'(i_depth);
    assign pix_valid = (d24 != 24'd0) && (d24 < {8'b0, i_cfg.depth_mode[15:0]});
    assign pix_last = (r_col == wlast) && (r_row == hlast);
    assign dx = $signed({2'b0, 16'(r_col), 4'b0}) - $signed({6'b0, i_cfg.principal_point[15:0]});
    assign dy = $signed({2'b0, 16'(r_row), 4'b0})
              - $signed({6'b0, i_cfg.principal_point[31:16]});
    assign pose_on  = i_cfg.depth_mode[17];
    assign row_sum  = r_acc + r_prod[37:0];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.step)
            STEP_X_MUL: begin
                mul_a = $signed({1'b0, i_cfg.inverse_focal[31:0]});
                mul_b = $signed({4'b0, r_magx});
            end
            STEP_Y_MUL: begin
                mul_a = $signed({1'b0, i_cfg.inverse_focal[63:32]});
                mul_b = $signed({4'b0, r_magy});
            end
            STEP_X_LO, STEP_Y_LO: begin
                mul_a = $signed({1'b0, r_prod[31:0]});
                mul_b = $signed(25'(r_d));
            end
            STEP_X_HI, STEP_Y_HI: begin
                mul_a = $signed(33'(r_mhi));
                mul_b = $signed(25'(r_d));
            end
            STEP_R00: begin mul_a = 33'($signed(i_cfg.rot0[15:0]));  mul_b = 25'(r_cx); end
            STEP_R01: begin mul_a = 33'($signed(i_cfg.rot0[31:16])); mul_b = 25'(r_cy); end
            STEP_R02: begin mul_a = 33'($signed(i_cfg.rot0[47:32])); mul_b = 25'(r_cz); end
            STEP_R10: begin mul_a = 33'($signed(i_cfg.rot1[15:0]));  mul_b = 25'(r_cx); end
            STEP_R11: begin mul_a = 33'($signed(i_cfg.rot1[31:16])); mul_b = 25'(r_cy); end
            STEP_R12: begin mul_a = 33'($signed(i_cfg.rot1[47:32])); mul_b = 25'(r_cz); end
            STEP_R20: begin mul_a = 33'($signed(i_cfg.rot2[15:0]));  mul_b = 25'(r_cx); end
            STEP_R21: begin mul_a = 33'($signed(i_cfg.rot2[31:16])); mul_b = 25'(r_cy); end
            STEP_R22: begin mul_a = 33'($signed(i_cfg.rot2[47:32])); mul_b = 25'(r_cz); end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_any    <= 1'b0;
            r_valid  <= 1'b0;
            r_last   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (r_col == wlast) begin
                    r_col <= '0;
                    r_row <= (r_row == hlast) ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
                r_valid <= pix_valid;
                r_last  <= pix_last;
                if (pix_last) begin
                    r_any <= 1'b0;
                end else if (pix_valid) begin
                    r_any <= 1'b1;
                end
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (i_cmd.load) begin
            r_d     <= i_depth;
            r_empty <= !(r_any || pix_valid);
            r_cr    <= i_cfg.depth_mode[16] ? i_red : 8'd0;
            r_cg    <= i_cfg.depth_mode[16] ? i_green : 8'd0;
            r_cb    <= i_cfg.depth_mode[16] ? i_blue : 8'd0;
            r_negx  <= dx[21];
            r_negy  <= dy[21];
            r_magx  <= dx[21] ? 21'(-dx) : 21'(dx);
            r_magy  <= dy[21] ? 21'(-dy) : 21'(dy);
        end
        if (i_cmd.run) begin
            unique case (i_cmd.step)
                STEP_X_LO, STEP_Y_LO: r_mhi <= r_prod[52:32];
                STEP_X_HI, STEP_Y_HI: r_plo <= r_prod[55:0];
                STEP_Y_MUL: r_cx <= deproj(r_prod[45:0], r_plo, r_negx);
                STEP_CAM_DONE: begin
                    r_cy <= deproj(r_prod[45:0], r_plo, r_negy);
                    r_cz <= (24'(r_d) > 24'd524287) ? 20'sd524287 : 20'(r_d);
                end
                STEP_R01, STEP_R11, STEP_R21: r_acc <= r_prod[37:0];
                STEP_R02, STEP_R12, STEP_R22: r_acc <= row_sum;
                STEP_R10: r_rx <= rot_out(row_sum, $signed(i_cfg.translation[19:0]));
                STEP_R20: r_ry <= rot_out(row_sum, $signed(i_cfg.translation[39:20]));
                STEP_POSE_DONE: r_rz <= rot_out(row_sum, $signed(i_cfg.translation[59:40]));
                default: r_acc <= r_acc;
            endcase
        end
        if (i_cmd.out_load) begin
            o_x           <= r_valid ? (pose_on ? r_rx : r_cx) : 20'd0;
            o_y           <= r_valid ? (pose_on ? r_ry : r_cy) : 20'd0;
            o_z           <= r_valid ? (pose_on ? r_rz : r_cz) : 20'd0;
            o_red         <= r_valid ? r_cr : 8'd0;
            o_green       <= r_valid ? r_cg : 8'd0;
            o_blue        <= r_valid ? r_cb : 8'd0;
            o_point_valid <= r_valid;
            o_frame_end   <= r_last;
            o_frame_empty <= r_last && r_empty;
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_sts.valid    = r_valid;
    assign o_sts.last     = r_last;
    assign o_sts.pose     = pose_on;
    assign o_sts.out_free = !r_ovalid || i_out_ready;

endmodule

FILE: verif/dtpc_checker.sv
// Checker for the depth to point cloud block: predicts each point and compares the output stream.
`timescale 1ns / 1ps
module dtpc_checker
    import dtpc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CfgIdxBits-1:0] i_cfg_addr,
    input  logic [63:0]           i_cfg_data,
    input  logic                  i_pix_valid,
    input  logic                  i_pix_ready,
    input  logic [39:0]           i_pix_data,
    input  logic                  i_pt_valid,
    input  logic                  i_pt_ready,
    input  logic [87:0]           i_pt_data,
    input  logic [1:0]            i_pt_user,
    input  logic                  i_pt_last,
    output int                    o_errors,
    output int                    o_pending
);

    typedef struct packed {
        logic [19:0] x;
        logic [19:0] y;
        logic [19:0] z;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        has_point;
        logic        frame_end;
        logic        frame_empty;
    } t_point;

    t_point      expected_points[$];
    t_cfg        cfg;
    logic [11:0] col_cnt;
    logic [11:0] row_cnt;
    logic        seen_point;

    assign o_pending = expected_points.size();

    function automatic longint clamp20(longint v);
        if (v > 524287) return 524287;
        if (v < -524288) return -524288;
        return v;
    endfunction

    function automatic longint deproject_axis(logic [11:0] coord, logic [15:0] c_q4,
                                              logic [31:0] inv, logic [63:0] d);
        longint      diff;
        logic [63:0] mag, prod, lo, hi, q;
        diff = longint'({coord, 4'd0}) - longint'(c_q4);
        mag  = (diff < 0) ? -diff : diff;
        prod = mag * {32'd0, inv};
        lo   = (prod & 64'hFFFF_FFFF) * d;
        hi   = (prod >> 32) * d;
        q    = (hi + ((lo + (64'd1 << 35)) >> 32)) >> 4;
        return (diff < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint rotate_row(logic [47:0] row, longint x, longint y, longint z,
                                          logic [19:0] t);
        longint s, mag, q;
        s = longint'($signed(row[15:0])) * x + longint'($signed(row[31:16])) * y
            + longint'($signed(row[47:32])) * z;
        mag = (s < 0) ? -s : s;
        q = (mag + 8192) >>> 14;
        if (s < 0) q = -q;
        return clamp20(q + longint'($signed(t)));
    endfunction

    function automatic logic predict_point(logic [39:0] pix, output t_point pt);
        logic [63:0] d;
        logic [11:0] wlast, hlast, u, v;
        logic        valid, last;
        longint      x, y, z, nx, ny, nz;
        d     = {48'd0, pix[15:0]};
        wlast = cfg.frame_size[11:0] - 12'd1;
        hlast = cfg.frame_size[23:12] - 12'd1;
        u     = col_cnt;
        v     = row_cnt;
        valid = (d > 0) && (d < {48'd0, cfg.depth_mode[15:0]});
        last  = (u == wlast) && (v == hlast);
        pt    = '0;
        if (u == wlast) begin
            col_cnt = '0;
            row_cnt = (v == hlast) ? '0 : v + 12'd1;
        end else begin
            col_cnt = u + 12'd1;
        end
        if (!valid && !last) return 1'b0;
        if (valid) begin
            x = clamp20(deproject_axis(u, cfg.principal_point[15:0],
                                       cfg.inverse_focal[31:0], d));
            y = clamp20(deproject_axis(v, cfg.principal_point[31:16],
                                       cfg.inverse_focal[63:32], d));
            z = clamp20(longint'(d));
            if (cfg.depth_mode[17]) begin
                nx = rotate_row(cfg.rot0, x, y, z, cfg.translation[19:0]);
                ny = rotate_row(cfg.rot1, x, y, z, cfg.translation[39:20]);
                nz = rotate_row(cfg.rot2, x, y, z, cfg.translation[59:40]);
                x = nx;
                y = ny;
                z = nz;
            end
            pt.x = x[19:0];
            pt.y = y[19:0];
            pt.z = z[19:0];
            if (cfg.depth_mode[16]) begin
                pt.red   = pix[39:32];
                pt.green = pix[31:24];
                pt.blue  = pix[23:16];
            end
            pt.has_point = 1'b1;
        end
        if (last) begin
            pt.frame_end   = 1'b1;
            pt.frame_empty = !(seen_point || valid);
            seen_point     = 1'b0;
        end else if (valid) begin
            seen_point = 1'b1;
        end
        return 1'b1;
    endfunction

    task automatic check_field(string name, logic [19:0] exp_val, logic [19:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_point pt;
        if (!i_rst_n) begin
            cfg.frame_size      = 24'd1966720;
            cfg.inverse_focal   = '0;
            cfg.principal_point = '0;
            cfg.depth_mode      = 18'd65535;
            cfg.rot0            = 48'd16384;
            cfg.rot1            = 48'd1073741824;
            cfg.rot2            = 48'd70368744177664;
            cfg.translation     = '0;
            col_cnt             = '0;
            row_cnt             = '0;
            seen_point          = 1'b0;
            expected_points.delete();
        end else begin
            if (i_pt_valid && i_pt_ready) begin
                if (expected_points.size() == 0) begin
                    $display("%0t: unexpected output, actual %h %b %b", $time, i_pt_data,
                             i_pt_user, i_pt_last);
                    o_errors++;
                end else begin
                    pt = expected_points.pop_front();
                    check_field("point_x", pt.x, i_pt_data[19:0]);
                    check_field("point_y", pt.y, i_pt_data[39:20]);
                    check_field("point_z", pt.z, i_pt_data[59:40]);
                    check_field("out_red", pt.red, i_pt_data[67:60]);
                    check_field("out_green", pt.green, i_pt_data[75:68]);
                    check_field("out_blue", pt.blue, i_pt_data[83:76]);
                    check_field("tdata pad", 20'd0, i_pt_data[87:84]);
                    check_field("point_valid", pt.has_point, i_pt_user[0]);
                    check_field("frame_empty", pt.frame_empty, i_pt_user[1]);
                    check_field("frame_end", pt.frame_end, i_pt_last);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_addr)
                    REG_FRAME_SIZE:      cfg.frame_size      = i_cfg_data[23:0];
                    REG_INVERSE_FOCAL:   cfg.inverse_focal   = i_cfg_data;
                    REG_PRINCIPAL_POINT: cfg.principal_point = i_cfg_data[31:0];
                    REG_DEPTH_MODE:      cfg.depth_mode      = i_cfg_data[17:0];
                    REG_ROTATION_ROW0:   cfg.rot0            = i_cfg_data[47:0];
                    REG_ROTATION_ROW1:   cfg.rot1            = i_cfg_data[47:0];
                    REG_ROTATION_ROW2:   cfg.rot2            = i_cfg_data[47:0];
                    REG_TRANSLATION:     cfg.translation     = i_cfg_data[59:0];
                    default: ;
                endcase
            end
            if (i_pix_valid && i_pix_ready) begin
                if (predict_point(i_pix_data, pt)) expected_points = {expected_points, pt};
            end
        end
    end

    initial o_errors = 0;

endmodule

FILE: verif/tb_top.sv
// Testbench top for the depth to point cloud block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
    import dtpc_pkg::*;

    localparam int IdleLimit = 3000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CfgIdxBits-1:0] i_cfg_addr;
    logic [63:0]           i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [39:0]           s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [87:0]           m_axis_tdata;
    logic [1:0]            m_axis_tuser;
    logic                  m_axis_tlast;
    int                    errors;
    int                    pending;
    int                    idle_cycles;
    logic [15:0]           max_depth;
    logic                  no_gaps;

    depth_to_point_cloud DUT (.*);

    dtpc_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_pix_valid (s_axis_tvalid),
        .i_pix_ready (s_axis_tready),
        .i_pix_data  (s_axis_tdata),
        .i_pt_valid  (m_axis_tvalid),
        .i_pt_ready  (m_axis_tready),
        .i_pt_data   (m_axis_tdata),
        .i_pt_user   (m_axis_tuser),
        .i_pt_last   (m_axis_tlast),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 12) return 0;
        if (roll < 19) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic cfg_write(logic [CfgIdxBits-1:0] addr, logic [63:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_addr  = addr;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Hold off until every point is out and the block has drained.
    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (25) @(posedge i_clk);
    endtask

    task automatic configure(logic [23:0] frame, logic [63:0] inv, logic [31:0] pp,
                             logic [17:0] mode, logic [47:0] r0, logic [47:0] r1,
                             logic [47:0] r2, logic [59:0] t);
        wait_drained();
        cfg_write(REG_FRAME_SIZE, {40'd0, frame});
        cfg_write(REG_INVERSE_FOCAL, inv);
        cfg_write(REG_PRINCIPAL_POINT, {32'd0, pp});
        cfg_write(REG_DEPTH_MODE, {46'd0, mode});
        cfg_write(REG_ROTATION_ROW0, {16'd0, r0});
        cfg_write(REG_ROTATION_ROW1, {16'd0, r1});
        cfg_write(REG_ROTATION_ROW2, {16'd0, r2});
        cfg_write(REG_TRANSLATION, {4'd0, t});
        max_depth = mode[15:0];
    endtask

    task automatic send_pixel(logic [15:0] depth, logic [7:0] blue, logic [7:0] green,
                              logic [7:0] red);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {red, green, blue, depth};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    function automatic logic [15:0] rand_depth(int zero_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < zero_pct) return 16'd0;
        if (roll < zero_pct + 8) return 16'($urandom());
        if (roll < zero_pct + 12) return max_depth;
        if (max_depth < 2) return 16'd1;
        return 16'($urandom_range(1, max_depth - 1));
    endfunction

    function automatic logic [47:0] rand_rotation();
        logic [47:0] r;
        r = 48'({$urandom(), $urandom()});
        if ($urandom_range(0, 3) == 0) r = {16'h8000, 16'h7FFF, 16'hC000};
        return r;
    endfunction

    task automatic random_phase(logic [11:0] w, logic [11:0] h, int pixels, int zero_pct);
        logic [17:0] mode;
        logic [63:0] inv;
        logic [59:0] t;
        int          roll;
        roll = $urandom_range(0, 7);
        mode = {2'($urandom_range(0, 3)), 16'($urandom())};
        if (roll == 0) mode[15:0] = 16'd0;
        if (roll == 1) mode[15:0] = 16'hFFFF;
        inv = {$urandom() >> $urandom_range(0, 31), $urandom() >> $urandom_range(0, 31)};
        if (roll == 2) inv = '1;
        t = 60'({$urandom(), $urandom()});
        if (roll == 3) t = {20'h80000, 20'h7FFFF, 20'h80000};
        configure({h, w}, inv, $urandom(), mode, rand_rotation(), rand_rotation(),
                  rand_rotation(), t);
        for (int i = 0; i < pixels; i++) begin
            send_pixel(rand_depth(zero_pct), 8'($urandom()), 8'($urandom()),
                       8'($urandom()));
        end
    endtask

    initial begin
        logic [11:0] w, h;
        int          fsize;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        max_depth     = 16'hFFFF;
        no_gaps       = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: depth limits, colour extremes, empty frame.
        configure({12'd2, 12'd4}, {32'h0100_0000, 32'h0080_0000}, {16'd24, 16'd40},
                  {2'b01, 16'd1000}, 48'd16384, 48'd1073741824, 48'd70368744177664, '0);
        send_pixel(16'd0, 8'h00, 8'hFF, 8'h00);
        send_pixel(16'd1, 8'hFF, 8'h00, 8'hFF);
        send_pixel(16'd999, 8'h12, 8'h34, 8'h56);
        send_pixel(16'd1000, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(16'hFFFF, 8'h00, 8'h00, 8'h00);
        send_pixel(16'd500, 8'hA5, 8'h5A, 8'hC3);
        send_pixel(16'd0, 8'h00, 8'h00, 8'h00);
        send_pixel(16'd0, 8'h00, 8'h00, 8'h00);
        for (int i = 0; i < 8; i++) send_pixel(16'd0, 8'hFF, 8'hFF, 8'hFF);

        // Directed: pose with saturating rotation, translation and focal extremes.
        configure({12'd2, 12'd3}, '1, 32'hFFFF_0000, {2'b11, 16'hFFFF},
                  {16'h8000, 16'h7FFF, 16'h8000}, {16'h7FFF, 16'h7FFF, 16'h7FFF},
                  {16'h0000, 16'h8000, 16'h7FFF}, {20'h80000, 20'h7FFFF, 20'h80000});
        send_pixel(16'hFFFE, 8'hFF, 8'h00, 8'hFF);
        send_pixel(16'd1, 8'h00, 8'hFF, 8'h00);
        send_pixel(16'hFFFF, 8'h11, 8'h22, 8'h33);
        send_pixel(16'h8000, 8'h44, 8'h55, 8'h66);
        send_pixel(16'd0, 8'h77, 8'h88, 8'h99);
        send_pixel(16'h7FFF, 8'hAA, 8'hBB, 8'hCC);

        // Directed: max depth zero leaves only the frame end.
        configure({12'd1, 12'd2}, '0, '0, 18'd0, '0, '0, '0, '0);
        send_pixel(16'd5, 8'h01, 8'h02, 8'h03);
        send_pixel(16'hFFFF, 8'h04, 8'h05, 8'h06);

        for (int p = 0; p < 8; p++) begin
            w       = 12'($urandom_range(1, 12));
            h       = 12'($urandom_range(1, 6));
            fsize   = int'(w) * int'(h);
            no_gaps = (p % 3 == 2);
            random_phase(w, h, (150 / fsize + 1) * fsize, 15);
        end
        no_gaps = 1'b0;

        // Zero height, then zero width: no frame end before the counters wrap.
        random_phase(12'd1, 12'd0, 120, 50);
        random_phase(12'd0, 12'd1, 120, 50);

        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        int gap;
        m_axis_tready = 1'b0;
        forever begin
            if ($urandom_range(0, 15) == 0) begin
                @(negedge i_clk);
                m_axis_tready = 1'b1;
                repeat ($urandom_range(50, 200)) @(negedge i_clk);
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    @(negedge i_clk);
                    m_axis_tready = 1'b0;
                    repeat (gap - 1) @(negedge i_clk);
                end
                @(negedge i_clk);
                m_axis_tready = 1'b1;
                repeat ($urandom_range(0, 7)) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IdleLimit) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

FILE: sim.f
rtl/dtpc_pkg.sv
rtl/dtpc_ctrl.sv
rtl/dtpc_dp.sv
rtl/depth_to_point_cloud.sv
verif/dtpc_checker.sv
verif/tb_top.sv
